### hw/rtl/gbalu_pkg.sv
// ----------------------------------------------------------------------------
// gbalu_pkg
// Shared types and constants for the handheld CPU arithmetic and flag unit.
// ----------------------------------------------------------------------------
package gbalu_pkg;

    // Operation codes
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_ADC   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_SBC   = 4'd3;
    localparam logic [3:0] OP_AND   = 4'd4;
    localparam logic [3:0] OP_XOR   = 4'd5;
    localparam logic [3:0] OP_OR    = 4'd6;
    localparam logic [3:0] OP_CP    = 4'd7;
    localparam logic [3:0] OP_INC   = 4'd8;
    localparam logic [3:0] OP_DEC   = 4'd9;
    localparam logic [3:0] OP_DAA   = 4'd10;
    localparam logic [3:0] OP_CPL   = 4'd11;
    localparam logic [3:0] OP_SCF   = 4'd12;
    localparam logic [3:0] OP_CCF   = 4'd13;
    localparam logic [3:0] OP_ADD16 = 4'd14;
    localparam logic [3:0] OP_ADDSP = 4'd15;

    // Decimal adjust corrections
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [15:0] result;
        flags_t      flags;
        logic        wr;
    } alu_res_t;

endpackage

### hw/rtl/gbalu_core.sv
// ----------------------------------------------------------------------------
// gbalu_core
// Combinational ALU: result, new flags and write-back strobe for one operation.
// ----------------------------------------------------------------------------
module gbalu_core
(
    input  logic [3:0]         op,
    input  logic [15:0]        operand_a,
    input  logic [15:0]        operand_b,
    input  gbalu_pkg::flags_t  flags,
    output gbalu_pkg::alu_res_t res
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] b_ext;
    logic [7:0]  daa_v;
    logic        daa_c;

    assign a   = operand_a[7:0];
    assign b   = operand_b[7:0];
    assign cin = flags.c;

    always_comb
    begin
        res   = '{result: 16'h0000, flags: flags, wr: 1'b1};
        sum9  = 9'd0;
        nib5  = 5'd0;
        sum17 = 17'd0;
        sum13 = 13'd0;
        b_ext = 16'h0000;
        daa_v = a;
        daa_c = cin;

        unique case (op) inside
            gbalu_pkg::OP_ADD, gbalu_pkg::OP_ADC:
            begin
                sum9 = {1'b0, a} + {1'b0, b} + {8'd0, (op == gbalu_pkg::OP_ADC) & cin};
                nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]}
                     + {4'd0, (op == gbalu_pkg::OP_ADC) & cin};
                res.result = {8'h00, sum9[7:0]};
                res.flags  = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: nib5[4], c: sum9[8]};
            end
            gbalu_pkg::OP_SUB, gbalu_pkg::OP_SBC, gbalu_pkg::OP_CP:
            begin
                // bit 8 / bit 4 of the widened difference is the borrow
                sum9 = {1'b0, a} - {1'b0, b} - {8'd0, (op == gbalu_pkg::OP_SBC) & cin};
                nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]}
                     - {4'd0, (op == gbalu_pkg::OP_SBC) & cin};
                res.result = {8'h00, sum9[7:0]};
                res.flags  = '{z: (sum9[7:0] == 8'h00), n: 1'b1, h: nib5[4], c: sum9[8]};
                res.wr     = (op != gbalu_pkg::OP_CP);
            end
            gbalu_pkg::OP_AND:
            begin
                res.result = {8'h00, a & b};
                res.flags  = '{z: ((a & b) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            gbalu_pkg::OP_XOR:
            begin
                res.result = {8'h00, a ^ b};
                res.flags  = '{z: ((a ^ b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            gbalu_pkg::OP_OR:
            begin
                res.result = {8'h00, a | b};
                res.flags  = '{z: ((a | b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            gbalu_pkg::OP_INC:
            begin
                daa_v      = a + 8'd1;
                res.result = {8'h00, daa_v};
                res.flags  = '{z: (daa_v == 8'h00), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
            end
            gbalu_pkg::OP_DEC:
            begin
                daa_v      = a - 8'd1;
                res.result = {8'h00, daa_v};
                res.flags  = '{z: (daa_v == 8'h00), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
            end
            gbalu_pkg::OP_DAA:
            begin
                if (!flags.n)
                begin
                    if (cin || (a > gbalu_pkg::DAA_HI_MAX))
                    begin
                        daa_v = daa_v + gbalu_pkg::DAA_HI_ADJ;
                        daa_c = 1'b1;
                    end
                    // +0x60 leaves the low nibble untouched
                    if (flags.h || (a[3:0] > gbalu_pkg::DAA_LO_MAX))
                    begin
                        daa_v = daa_v + gbalu_pkg::DAA_LO_ADJ;
                    end
                end
                else
                begin
                    if (cin)
                    begin
                        daa_v = daa_v - gbalu_pkg::DAA_HI_ADJ;
                    end
                    if (flags.h)
                    begin
                        daa_v = daa_v - gbalu_pkg::DAA_LO_ADJ;
                    end
                end
                res.result = {8'h00, daa_v};
                res.flags  = '{z: (daa_v == 8'h00), n: flags.n, h: 1'b0, c: daa_c};
            end
            gbalu_pkg::OP_CPL:
            begin
                res.result = {8'h00, ~a};
                res.flags  = '{z: flags.z, n: 1'b1, h: 1'b1, c: cin};
            end
            gbalu_pkg::OP_SCF:
            begin
                res.wr    = 1'b0;
                res.flags = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
            end
            gbalu_pkg::OP_CCF:
            begin
                res.wr    = 1'b0;
                res.flags = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~cin};
            end
            gbalu_pkg::OP_ADD16:
            begin
                sum17 = {1'b0, operand_a} + {1'b0, operand_b};
                sum13 = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
                res.result = sum17[15:0];
                res.flags  = '{z: flags.z, n: 1'b0, h: sum13[12], c: sum17[16]};
            end
            gbalu_pkg::OP_ADDSP:
            begin
                // carries come from the unsigned low-byte add
                b_ext = {{8{b[7]}}, b};
                sum9  = {1'b0, a} + {1'b0, b};
                nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                res.result = operand_a + b_ext;
                res.flags  = '{z: 1'b0, n: 1'b0, h: nib5[4], c: sum9[8]};
            end
            default:
            begin
                res.wr = 1'b1;
            end
        endcase
    end

endmodule

### hw/rtl/gameboy_cpu_alu_flags.sv
// ----------------------------------------------------------------------------
// gameboy_cpu_alu_flags
// Arithmetic and flag unit of an 8-bit handheld console CPU, stream wrapped.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+--------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser: op; tdata: operand_a, operand_b
//  m_*      | out | m_tvalid/m_tready  | tdata: result, Z, N, H, C, write strobe
//
//  The result is registered: the input register, then the ALU into the result
//  register. One transaction per cycle is sustained while m_tready stays high;
//  the flag register is written as each operation enters the result register,
//  so the next operation always sees up-to-date flags.
//  rst_n clears both valid bits and the flags (all zero).
//  A stalled result holds in place; the input stage still moves up while
//  the result register is empty or being drained.
//
module gameboy_cpu_alu_flags
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] operand_a, [31:16] operand_b
    input  logic [3:0]  s_tuser,   // [3:0] op

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] result, [16] zero_flag, [17] subtract_flag,
                                   // [18] half_carry_flag, [19] carry_flag,
                                   // [20] writes_result, [23:21] zero
);

    // Input stage
    logic        in_vld_reg;
    logic [3:0]  in_op_reg;
    logic [15:0] in_a_reg;
    logic [15:0] in_b_reg;

    // Processor flags, held across operations
    gbalu_pkg::flags_t flags_reg;

    // Result stage
    logic                out_vld_reg;
    gbalu_pkg::alu_res_t out_res_reg;

    gbalu_pkg::alu_res_t alu_res;
    logic                adv;        // input stage moves into result register
    logic                s_xfer;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign s_xfer   = s_tvalid && s_tready;

    gbalu_core u_core
    (
        .op        (in_op_reg),
        .operand_a (in_a_reg),
        .operand_b (in_b_reg),
        .flags     (flags_reg),
        .res       (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            flags_reg   <= '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_vld_reg <= 1'b1;
                flags_reg   <= alu_res.flags;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_op_reg <= s_tuser;
            in_a_reg  <= s_tdata[15:0];
            in_b_reg  <= s_tdata[31:16];
        end
        if (adv)
        begin
            out_res_reg <= alu_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.wr,
                       out_res_reg.flags.c,
                       out_res_reg.flags.h,
                       out_res_reg.flags.n,
                       out_res_reg.flags.z,
                       out_res_reg.result};

endmodule

### hw/rtl/gbalu_checker.sv
// ----------------------------------------------------------------------------
// gbalu_checker
// Port-level checks for the ALU stream wrapper, bound to the top level.
// ----------------------------------------------------------------------------
module gbalu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty result register always lets the input stage move
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // downstream ready must propagate to the input side
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    // pad bits stay clear on every result
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] == 3'b000))
        else $error("non-zero pad bits in result");

endmodule

bind gameboy_cpu_alu_flags gbalu_checker u_gbalu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the handheld CPU arithmetic and flag unit.
// Operations go in on the slave stream with random gaps and the results are
// drained with random back-pressure. Each input transaction is run through a
// flag-tracking predictor and each result transaction is compared with the
// oldest prediction. Directed corner cases come first, then random traffic
// that is weighted towards BCD add/subtract followed by a decimal adjust.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int IDLE_PCT     = 32;

    // One operation as it goes onto the slave stream
    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] opa;
        logic [15:0] opb;
    } alu_op_t;

    // What one operation should produce on the master stream
    typedef struct packed {
        logic [15:0]       result;
        gbalu_pkg::flags_t flags;
        logic              wr;
    } outcome_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [15:0] operand_a, [31:16] operand_b
    logic [3:0]  s_tuser  = '0;   // [3:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [15:0] result, [16] Z, [17] N, [18] H, [19] C,
                                  // [20] writes_result

    alu_op_t           issue_q[$];         // operations still to be sent
    outcome_t          outcome_q[$];       // predictions awaiting their result
    gbalu_pkg::flags_t model_flags = '0;   // predictor's copy of the flag register

    int          issued_count  = 0;
    int          results_seen  = 0;
    int          mismatch_count = 0;
    int          cycle_count   = 0;
    logic [15:0] ops_seen      = '0;
    logic        quiet_stretch;

    gameboy_cpu_alu_flags dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Neither side idles for a while in the middle of the random traffic
    assign quiet_stretch = (issued_count >= 800) && (issued_count < 1100);

    // ------------------------------------------------------------------------
    // Predictor: result and new flags for one operation, in issue order.
    // The flag register is updated here, so this must be called exactly once
    // per accepted transaction.
    // ------------------------------------------------------------------------
    function automatic outcome_t compute_alu_outcome(input alu_op_t it);
        logic [7:0]        a;
        logic [7:0]        b;
        logic [7:0]        r;
        logic [7:0]        v;
        logic              cin;
        logic              ci;
        logic [8:0]        wide;
        logic [4:0]        nib;
        logic [16:0]       wide16;
        logic [12:0]       wide12;
        gbalu_pkg::flags_t nf;
        outcome_t          o;
        a        = it.opa[7:0];
        b        = it.opb[7:0];
        cin      = model_flags.c;
        nf       = model_flags;
        r        = 8'h00;
        o.result = '0;
        o.wr     = 1'b1;
        case (it.op)
            gbalu_pkg::OP_ADD, gbalu_pkg::OP_ADC:
            begin
                ci   = (it.op == gbalu_pkg::OP_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, b} + {8'd0, ci};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
                r    = wide[7:0];
                nf   = '{r == 8'h00, 1'b0, nib[4], wide[8]};
            end
            gbalu_pkg::OP_SUB, gbalu_pkg::OP_SBC, gbalu_pkg::OP_CP:
            begin
                // a borrow shows as the sign bit of the widened difference
                ci   = (it.op == gbalu_pkg::OP_SBC) ? cin : 1'b0;
                wide = {1'b0, a} - {1'b0, b} - {8'd0, ci};
                nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
                r    = wide[7:0];
                nf   = '{r == 8'h00, 1'b1, nib[4], wide[8]};
                if (it.op == gbalu_pkg::OP_CP)
                    o.wr = 1'b0;
            end
            gbalu_pkg::OP_AND:
            begin
                r  = a & b;
                nf = '{r == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            gbalu_pkg::OP_XOR:
            begin
                r  = a ^ b;
                nf = '{r == 8'h00, 1'b0, 1'b0, 1'b0};
            end
            gbalu_pkg::OP_OR:
            begin
                r  = a | b;
                nf = '{r == 8'h00, 1'b0, 1'b0, 1'b0};
            end
            gbalu_pkg::OP_INC:
            begin
                r  = a + 8'h01;
                nf = '{r == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
            end
            gbalu_pkg::OP_DEC:
            begin
                r  = a - 8'h01;
                nf = '{r == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
            end
            gbalu_pkg::OP_DAA:
            begin
                v  = a;
                ci = cin;
                if (!model_flags.n)
                begin
                    if (cin || a > 8'h99)
                    begin
                        v  = v + 8'h60;
                        ci = 1'b1;
                    end
                    if (model_flags.h || v[3:0] > 4'h9)
                        v = v + 8'h06;
                end
                else
                begin
                    if (cin)
                        v = v - 8'h60;
                    if (model_flags.h)
                        v = v - 8'h06;
                end
                r  = v;
                nf = '{r == 8'h00, model_flags.n, 1'b0, ci};
            end
            gbalu_pkg::OP_CPL:
            begin
                r  = ~a;
                nf = '{model_flags.z, 1'b1, 1'b1, cin};
            end
            gbalu_pkg::OP_SCF:
            begin
                o.wr = 1'b0;
                nf   = '{model_flags.z, 1'b0, 1'b0, 1'b1};
            end
            gbalu_pkg::OP_CCF:
            begin
                o.wr = 1'b0;
                nf   = '{model_flags.z, 1'b0, 1'b0, ~cin};
            end
            gbalu_pkg::OP_ADD16:
            begin
                wide16   = {1'b0, it.opa} + {1'b0, it.opb};
                wide12   = {1'b0, it.opa[11:0]} + {1'b0, it.opb[11:0]};
                o.result = wide16[15:0];
                nf       = '{model_flags.z, 1'b0, wide12[12], wide16[16]};
            end
            gbalu_pkg::OP_ADDSP:
            begin
                // signed offset for the sum, unsigned low-byte add for H and C
                o.result = it.opa + {{8{b[7]}}, b};
                nib      = {1'b0, it.opa[3:0]} + {1'b0, b[3:0]};
                wide     = {1'b0, it.opa[7:0]} + {1'b0, b};
                nf       = '{1'b0, 1'b0, nib[4], wide[8]};
            end
        endcase
        if (it.op != gbalu_pkg::OP_ADD16 && it.op != gbalu_pkg::OP_ADDSP)
            o.result = {8'h00, r};
        model_flags = nf;
        o.flags     = nf;
        return o;
    endfunction

    task automatic queue_op(input logic [3:0] op, input logic [15:0] opa,
                            input logic [15:0] opb);
        alu_op_t item;
        item    = '{op, opa, opb};
        issue_q = {issue_q, item};
    endtask

    // Random operand, now and then one of the awkward edge values
    function automatic logic [15:0] pick_operand();
        logic [15:0] edges[8];
        edges = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                  16'h000F, 16'h0080, 16'h7FFF, 16'h8000};
        if ($urandom_range(99) < 15)
            return edges[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    // Two packed BCD digits in the low byte, junk in the high byte
    function automatic logic [15:0] pick_bcd();
        return {8'($urandom), 4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the next queued operation whenever the slave channel is
    // free, with random gaps. Each accepted transaction is predicted here.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        alu_op_t  nxt;
        outcome_t pred;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pred      = compute_alu_outcome({s_tuser, s_tdata[15:0], s_tdata[31:16]});
                outcome_q = {outcome_q, pred};
                ops_seen[s_tuser] <= 1'b1;
                issued_count      <= issued_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (issue_q.size() != 0 &&
                    (quiet_stretch || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt       = issue_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {nxt.opb, nxt.opa};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure on the master channel, and a field by
    // field check of every result transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (outcome_q.size() == 0)
                begin
                    $error("result transaction %0h with nothing outstanding", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("result", want.result, m_tdata[15:0]);
                    check_field("zero_flag", 16'(want.flags.z), 16'(m_tdata[16]));
                    check_field("subtract_flag", 16'(want.flags.n), 16'(m_tdata[17]));
                    check_field("half_carry_flag", 16'(want.flags.h), 16'(m_tdata[18]));
                    check_field("carry_flag", 16'(want.flags.c), 16'(m_tdata[19]));
                    check_field("writes_result", 16'(want.wr), 16'(m_tdata[20]));
                end
            end
            m_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d predictions outstanding",
                     cycle_count, outcome_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int          n;
        logic [3:0]  arith;
        // Directed: wrap to zero, half and full carries, borrows
        queue_op(gbalu_pkg::OP_ADD,   16'h0000, 16'h0000);
        queue_op(gbalu_pkg::OP_ADD,   16'hA5FF, 16'h5A01);   // wraps to zero, sets H and C
        queue_op(gbalu_pkg::OP_ADC,   16'h0000, 16'h00FF);   // old carry pushes it over
        queue_op(gbalu_pkg::OP_ADD,   16'h000F, 16'h0001);
        queue_op(gbalu_pkg::OP_SUB,   16'h0000, 16'h0001);   // borrow from both nibbles
        queue_op(gbalu_pkg::OP_SBC,   16'h0010, 16'h000F);   // with old carry
        // compare: difference on result, nothing written; high bytes ignored
        queue_op(gbalu_pkg::OP_CP,    16'h003C, 16'h003C);
        queue_op(gbalu_pkg::OP_CP,    16'hFF3C, 16'hAB40);
        queue_op(gbalu_pkg::OP_AND,   16'h00FF, 16'hFF00);
        queue_op(gbalu_pkg::OP_XOR,   16'h125A, 16'h345A);
        queue_op(gbalu_pkg::OP_OR,    16'hFF00, 16'h00FF);
        queue_op(gbalu_pkg::OP_INC,   16'h00FF, 16'h0000);
        queue_op(gbalu_pkg::OP_INC,   16'h000F, 16'hFFFF);
        queue_op(gbalu_pkg::OP_DEC,   16'h0001, 16'h0000);
        queue_op(gbalu_pkg::OP_DEC,   16'h0000, 16'h0000);
        // decimal adjust after BCD add, after add with carry out, after sub
        queue_op(gbalu_pkg::OP_ADD,   16'h0045, 16'h0038);
        queue_op(gbalu_pkg::OP_DAA,   16'h007D, 16'h0000);
        queue_op(gbalu_pkg::OP_ADD,   16'h0099, 16'h0099);
        queue_op(gbalu_pkg::OP_DAA,   16'h0032, 16'h0000);
        queue_op(gbalu_pkg::OP_SUB,   16'h0042, 16'h0015);
        queue_op(gbalu_pkg::OP_DAA,   16'h002D, 16'h0000);
        queue_op(gbalu_pkg::OP_CPL,   16'h00A5, 16'h0000);
        // flag-only operations: zero result, no write
        queue_op(gbalu_pkg::OP_SCF,   16'hFFFF, 16'hFFFF);
        queue_op(gbalu_pkg::OP_CCF,   16'h0000, 16'h0000);
        queue_op(gbalu_pkg::OP_CCF,   16'h1234, 16'h5678);
        queue_op(gbalu_pkg::OP_ADD16, 16'hFFFF, 16'h0001);
        queue_op(gbalu_pkg::OP_ADD16, 16'h0FFF, 16'h0001);
        queue_op(gbalu_pkg::OP_ADDSP, 16'hFFF8, 16'hAB08);   // high byte of the offset ignored
        queue_op(gbalu_pkg::OP_ADDSP, 16'h0000, 16'h0080);   // most negative offset

        // Random: mostly single operations, with BCD add/sub + DAA runs mixed in
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 25)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        queue_op(gbalu_pkg::OP_SCF, pick_operand(), pick_operand());
                        n++;
                    end
                    1:
                    begin
                        queue_op(gbalu_pkg::OP_CCF, pick_operand(), pick_operand());
                        n++;
                    end
                    default: ;
                endcase
                case ($urandom_range(3))
                    0:       arith = gbalu_pkg::OP_ADD;
                    1:       arith = gbalu_pkg::OP_ADC;
                    2:       arith = gbalu_pkg::OP_SUB;
                    default: arith = gbalu_pkg::OP_SBC;
                endcase
                queue_op(arith, pick_bcd(), pick_bcd());
                queue_op(gbalu_pkg::OP_DAA, pick_bcd(), pick_operand());
                n += 2;
            end
            else
            begin
                queue_op(4'($urandom_range(15)), pick_operand(), pick_operand());
                n++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (issue_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (outcome_q.size() != 0)
            @(posedge clk);
        // anything that turns up late is flagged
        repeat (8) @(posedge clk);

        if (outcome_q.size() != 0)
        begin
            $error("%0d predictions never matched by a result", outcome_q.size());
            mismatch_count++;
        end
        $display("run: %0d operations sent, %0d results checked, %0d of 16 opcodes used",
                 issued_count, results_seen, $countones(ops_seen));
        $display("run: directed corners, BCD add/sub with decimal adjust, random stalls");
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
